FILE: rtl/core/cda_pkg.sv
// shared types, constants and calendar helper functions for the date-time adder
package cda_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 43699
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  // floor(x / 7) = (x * 37450) >> 18, exact for x below 43693
  localparam logic [15:0] DIV7_MUL     = 16'd37450;
  localparam int unsigned DIV7_SHIFT   = 18;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_ADD  = 1'b1
  } action_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  typedef struct packed {
    action_e   action;
    datetime_t dt;
  } item_t;

  // checked transaction handed to the state update
  typedef struct packed {
    action_e   action;
    logic      time_ok;
    logic      load_ok;
    datetime_t dt;
    logic [6:0] mod100;
    logic [1:0] cent4;
  } check_t;

  typedef struct packed {
    datetime_t dt;
    logic      accepted;
  } result_t;

  typedef struct packed {
    result_t    res;
    logic [2:0] weekday;
  } out_t;

  // leap from year mod 4, year mod 100 and (year / 100) mod 4
  function automatic logic is_leap(input logic [1:0] mod4, input logic [6:0] mod100,
                                   input logic [1:0] cent4);
    return ((mod4 == 2'd0) && (mod100 != 7'd0)) || ((mod100 == 7'd0) && (cent4 == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    if (month == MONTH_FEB) begin
      return leap ? 5'd29 : 5'd28;
    end else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      return 5'd30;
    end else if (month inside {[MONTH_JAN:MONTH_DEC]}) begin
      return 5'd31;
    end else begin
      return 5'd0;
    end
  endfunction

  // (31 * mm) / 12 with mm the month shifted to start in march
  function automatic logic [4:0] month_offset(input logic [3:0] month);
    logic [4:0] off;
    case (month)
      MONTH_JAN: off = 5'd28;
      MONTH_FEB: off = 5'd31;
      MONTH_MAR: off = 5'd2;
      MONTH_APR: off = 5'd5;
      MONTH_MAY: off = 5'd7;
      MONTH_JUN: off = 5'd10;
      MONTH_JUL: off = 5'd12;
      MONTH_AUG: off = 5'd15;
      MONTH_SEP: off = 5'd18;
      MONTH_OCT: off = 5'd20;
      MONTH_NOV: off = 5'd23;
      MONTH_DEC: off = 5'd25;
      default:   off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/core/cda_load_check.sv
// input register and validity check stage for load and add transactions
module cda_load_check import cda_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  item_t  in_item_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output check_t out_chk_o
);

  logic   a_valid_q;
  item_t  a_item_q;
  logic   b_valid_q;
  check_t b_chk_q;
  logic   a_ready;
  logic   b_ready;
  check_t chk_d;

  logic [26:0] prod;
  logic [7:0]  cent;
  logic [13:0] cent_x100;
  logic [13:0] rem;
  logic        leap;
  logic [4:0]  dim;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    prod      = 27'(a_item_q.dt.year) * 27'(DIV100_MUL);
    cent      = 8'(prod >> DIV100_SHIFT);
    // cent * 100 as shifts
    cent_x100 = (14'(cent) << 6) + (14'(cent) << 5) + (14'(cent) << 2);
    rem       = a_item_q.dt.year - cent_x100;
    leap      = is_leap(a_item_q.dt.year[1:0], rem[6:0], cent[1:0]);
    dim       = days_in(a_item_q.dt.month, leap);

    chk_d.action  = a_item_q.action;
    chk_d.dt      = a_item_q.dt;
    chk_d.mod100  = rem[6:0];
    chk_d.cent4   = cent[1:0];
    chk_d.time_ok = (a_item_q.dt.hour < 5'd24) && (a_item_q.dt.minute < 6'd60) &&
                    (a_item_q.dt.second < 6'd60);
    chk_d.load_ok = chk_d.time_ok && (a_item_q.dt.year <= YEAR_MAX) &&
                    (a_item_q.dt.day != 5'd0) && (a_item_q.dt.day <= dim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_item_q <= in_item_i;
    end
    if (a_valid_q && b_ready) begin
      b_chk_q <= chk_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_chk_o   = b_chk_q;

endmodule

FILE: rtl/core/cda_state_update.sv
// current date-time register with load and carry-ripple add, plus result register
module cda_state_update import cda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  check_t  in_chk_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  datetime_t cur_q;
  datetime_t cur_d;
  logic [6:0] m100_q;
  logic [6:0] m100_d;
  logic [1:0] c4_q;
  logic [1:0] c4_d;
  logic       res_valid_q;
  result_t    res_q;
  logic       acc;
  logic       advance;

  logic [6:0] sec_sum;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;
  logic [5:0] day_sum;
  logic       carry_s;
  logic       carry_m;
  logic       carry_h;
  logic       carry_d;
  logic       carry_y;
  logic       cur_leap;
  logic [4:0] dim;
  datetime_t  add_dt;
  logic [6:0] add_m100;
  logic [1:0] add_c4;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;

  always_comb begin
    cur_leap = is_leap(cur_q.year[1:0], m100_q, c4_q);
    dim      = days_in(cur_q.month, cur_leap);

    sec_sum  = 7'(cur_q.second) + 7'(in_chk_i.dt.second);
    carry_s  = sec_sum >= 7'd60;
    min_sum  = 7'(cur_q.minute) + 7'(in_chk_i.dt.minute) + 7'(carry_s);
    carry_m  = min_sum >= 7'd60;
    hour_sum = 6'(cur_q.hour) + 6'(in_chk_i.dt.hour) + 6'(carry_m);
    carry_h  = hour_sum >= 6'd24;
    day_sum  = 6'(cur_q.day) + 6'(carry_h);
    carry_d  = day_sum > 6'(dim);
    carry_y  = carry_d && (cur_q.month == MONTH_DEC);

    add_dt.second = carry_s ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
    add_dt.minute = carry_m ? 6'(min_sum - 7'd60) : min_sum[5:0];
    add_dt.hour   = carry_h ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
    add_dt.day    = carry_d ? 5'd1 : day_sum[4:0];
    add_dt.month  = carry_y ? MONTH_JAN : (carry_d ? cur_q.month + 4'd1 : cur_q.month);
    add_dt.year   = carry_y ? cur_q.year + 14'd1 : cur_q.year;
    add_m100      = m100_q;
    add_c4        = c4_q;
    if (carry_y) begin
      add_m100 = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
      add_c4   = (m100_q == 7'd99) ? c4_q + 2'd1 : c4_q;
    end
    // saturate at the end of the last representable year
    if (carry_y && (cur_q.year == YEAR_MAX)) begin
      add_dt.year   = YEAR_MAX;
      add_dt.month  = MONTH_DEC;
      add_dt.day    = 5'd31;
      add_dt.hour   = 5'd23;
      add_dt.minute = 6'd59;
      add_dt.second = 6'd59;
      add_m100      = m100_q;
      add_c4        = c4_q;
    end

    cur_d  = cur_q;
    m100_d = m100_q;
    c4_d   = c4_q;
    acc    = 1'b0;
    case (in_chk_i.action)
      ACT_LOAD: begin
        if (in_chk_i.load_ok) begin
          cur_d  = in_chk_i.dt;
          m100_d = in_chk_i.mod100;
          c4_d   = in_chk_i.cent4;
          acc    = 1'b1;
        end
      end
      ACT_ADD: begin
        if (in_chk_i.time_ok) begin
          cur_d  = add_dt;
          m100_d = add_m100;
          c4_d   = add_c4;
          acc    = 1'b1;
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.year   <= 14'd1;
      cur_q.month  <= MONTH_JAN;
      cur_q.day    <= 5'd1;
      cur_q.hour   <= 5'd0;
      cur_q.minute <= 6'd0;
      cur_q.second <= 6'd0;
      m100_q       <= 7'd1;
      c4_q         <= 2'd0;
      res_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        cur_q  <= cur_d;
        m100_q <= m100_d;
        c4_q   <= c4_d;
      end
      if (in_ready_o) begin
        res_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.dt       <= cur_d;
      res_q.accepted <= acc;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.month >= MONTH_JAN) && (cur_q.month <= MONTH_DEC))
    else $error("current month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.day != 5'd0) && (cur_q.day <= dim))
    else $error("current day outside month length");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.hour < 5'd24) && (cur_q.minute < 6'd60) && (cur_q.second < 6'd60))
    else $error("current time of day out of range");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !acc) |=> ($stable(cur_q) && $stable(m100_q) && $stable(c4_q)))
    else $error("rejected transaction changed the date-time");

  a_leap_tracks_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && acc && (in_chk_i.action == ACT_ADD) && carry_y && (m100_q != 7'd99) &&
     (cur_q.year != YEAR_MAX)) |=> (m100_q == $past(m100_q) + 7'd1))
    else $error("year mod 100 tracking lost step");

endmodule

FILE: rtl/core/cda_weekday.sv
// three-stage weekday pipeline whose last stage is the output register
module cda_weekday import cda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_o
);

  logic       d_valid_q;
  result_t    d_res_q;
  logic [13:0] d_yy_q;
  logic [6:0] d_q100_q;
  logic [4:0] d_off_q;
  logic       e_valid_q;
  result_t    e_res_q;
  logic [14:0] e_sum_q;
  logic       f_valid_q;
  out_t       f_out_q;

  logic d_ready;
  logic e_ready;
  logic f_ready;

  logic        jan_feb;
  logic [13:0] yy_d;
  logic [26:0] prod100;
  logic [6:0]  q100_d;
  logic [14:0] sum_d;
  logic [30:0] prod7;
  logic [12:0] q7;
  logic [15:0] rem;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign d_ready    = !d_valid_q || e_ready;
  assign in_ready_o = d_ready;

  always_comb begin
    // january and february count as months of the previous year
    jan_feb = (in_res_i.dt.month == MONTH_JAN) || (in_res_i.dt.month == MONTH_FEB);
    yy_d    = in_res_i.dt.year + 14'd400 - 14'(jan_feb);
    prod100 = 27'(yy_d) * 27'(DIV100_MUL);
    q100_d  = 7'(prod100 >> DIV100_SHIFT);

    sum_d = 15'(d_res_q.dt.day) + 15'(d_yy_q) + 15'(d_yy_q >> 2) + 15'(d_off_q) +
            15'(d_q100_q >> 2) - 15'(d_q100_q);

    prod7 = 31'(e_sum_q) * 31'(DIV7_MUL);
    q7    = 13'(prod7 >> DIV7_SHIFT);
    rem   = 16'(e_sum_q) - ({q7, 3'b000} - 16'(q7));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid_q <= in_valid_i;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
      if (f_ready) begin
        f_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && d_ready) begin
      d_res_q  <= in_res_i;
      d_yy_q   <= yy_d;
      d_q100_q <= q100_d;
      d_off_q  <= month_offset(in_res_i.dt.month);
    end
    if (d_valid_q && e_ready) begin
      e_res_q <= d_res_q;
      e_sum_q <= sum_d;
    end
    if (e_valid_q && f_ready) begin
      f_out_q.res     <= e_res_q;
      f_out_q.weekday <= rem[2:0];
    end
  end

  assign out_valid_o = f_valid_q;
  assign out_o       = f_out_q;

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid_q |-> (f_out_q.weekday < 3'd7))
    else $error("weekday out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid_q && !out_ready_i) |=> (f_valid_q && $stable(f_out_q)))
    else $error("output register changed while stalled");

  a_next_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && f_ready && f_valid_q && out_ready_i &&
     (e_res_q.dt.year == f_out_q.res.dt.year) && (e_res_q.dt.month == f_out_q.res.dt.month) &&
     (e_res_q.dt.day == f_out_q.res.dt.day + 5'd1) && (f_out_q.weekday != 3'd6))
    |=> (f_out_q.weekday == $past(f_out_q.weekday) + 3'd1))
    else $error("weekday of consecutive days does not step");

endmodule

FILE: rtl/core/calendar_datetime_adder.sv
// top level of the gregorian date-time register with add, load and weekday output
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------------
//   in      | in_valid_i / in_stall_o | action, year, month, day, hours, minutes, seconds
//   out     | out_valid_o/out_stall_i | out_year..out_second, weekday, accepted
//
// one transaction per cycle sustained while out_stall_i is low, through the stages below
// six register stages: input, check, date-time update, two weekday stages, output
// the update's carry logic reads its own register, so back-to-back adds chain correctly
// reset sets 0001-01-01 00:00:00 and empties every stage
// out_stall_i holds the output; stages behind it keep filling until each is occupied
module calendar_datetime_adder import cda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hours_i,
  input  logic [5:0]  minutes_i,
  input  logic [5:0]  seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o,
  output logic [2:0]  weekday_o,
  output logic        accepted_o
);

  item_t   in_item;
  logic    in_ready;
  logic    chk_valid;
  logic    chk_ready;
  check_t  chk;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  out_t    out_data;

  always_comb begin
    in_item.action    = action_e'(action_i);
    in_item.dt.year   = year_i;
    in_item.dt.month  = month_i;
    in_item.dt.day    = day_i;
    in_item.dt.hour   = hours_i;
    in_item.dt.minute = minutes_i;
    in_item.dt.second = seconds_i;
  end

  cda_load_check u_load_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (chk_valid),
    .out_ready_i (chk_ready),
    .out_chk_o   (chk)
  );

  cda_state_update u_state_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chk_valid),
    .in_ready_o  (chk_ready),
    .in_chk_i    (chk),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_res_o   (res)
  );

  cda_weekday u_weekday (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_res_i    (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_o       (out_data)
  );

  assign in_stall_o   = !in_ready;
  assign out_year_o   = out_data.res.dt.year;
  assign out_month_o  = out_data.res.dt.month;
  assign out_day_o    = out_data.res.dt.day;
  assign out_hour_o   = out_data.res.dt.hour;
  assign out_minute_o = out_data.res.dt.minute;
  assign out_second_o = out_data.res.dt.second;
  assign weekday_o    = out_data.weekday;
  assign accepted_o   = out_data.res.accepted;

endmodule
